FILE: hdl/kh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package kh_pkg;

    localparam int LIST_SIZE   = 256;
    localparam int LIST_AW     = $clog2(LIST_SIZE);
    localparam int DATA_W      = 8;
    localparam int LEN_W       = 9;
    localparam int VALUE_W     = 16;

    localparam int MAX_KEY     = 64;
    localparam int KEY_AW      = (MAX_KEY > 1) ? $clog2(MAX_KEY) : 1;
    localparam int COUNT_W     = $clog2(MAX_KEY + 1);

    localparam int SUFFIX_LEN  = 5;
    localparam int SUFFIX_AW   = 3;
    localparam int K_W         = $clog2(MAX_KEY + SUFFIX_LEN + 1);

    localparam int ROUNDS      = 64;
    localparam int ROUND_W     = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;

    localparam int DENSE_GROUP = 16;
    localparam int GRP_AW      = $clog2(DENSE_GROUP);

    localparam int SWAP_W      = LIST_AW - 1;

    typedef logic [1:0] rd_sel_t;

    localparam rd_sel_t RD_SWAP  = 2'd0;
    localparam rd_sel_t RD_DENSE = 2'd1;
    localparam rd_sel_t RD_PROD  = 2'd2;

    typedef struct packed {
        logic    key_wr;
        logic    init;
        logic    load;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    wr_a;
        logic    wr_b;
        logic    swap_inc;
        logic    adv;
        logic    round_next;
        logic    acc_upd;
        logic    dense_inc;
        logic    prod_load;
        logic    out_load;
        logic    clr_count;
    } kh_cmd_t;

    typedef struct packed {
        logic mode;
        logic k_done;
        logic round_last;
        logic swap_needed;
        logic swap_last;
        logic grp_end;
        logic dense_done;
        logic out_free;
    } kh_status_t;

    function automatic logic [LEN_W-1:0] suffix_len(input logic [SUFFIX_AW-1:0] idx);
        logic [LEN_W-1:0] v;
        case (idx)
            3'd0:    v = 9'd17;
            3'd1:    v = 9'd31;
            3'd2:    v = 9'd73;
            3'd3:    v = 9'd47;
            3'd4:    v = 9'd23;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/kh_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module kh_ctrl
    import kh_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    input  wire logic       s_tlast,
    output logic            s_tready,
    input  kh_status_t      status,
    output kh_cmd_t         cmd
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_INIT   = 4'd1;
    localparam logic [3:0] ST_NEXT   = 4'd2;
    localparam logic [3:0] ST_FETCH  = 4'd3;
    localparam logic [3:0] ST_LOAD   = 4'd4;
    localparam logic [3:0] ST_CHK    = 4'd5;
    localparam logic [3:0] ST_SW_RD  = 4'd6;
    localparam logic [3:0] ST_SW_WA  = 4'd7;
    localparam logic [3:0] ST_SW_WB  = 4'd8;
    localparam logic [3:0] ST_ADV    = 4'd9;
    localparam logic [3:0] ST_DN_RD  = 4'd10;
    localparam logic [3:0] ST_DN_AC  = 4'd11;
    localparam logic [3:0] ST_DN_OUT = 4'd12;
    localparam logic [3:0] ST_PR_RD  = 4'd13;
    localparam logic [3:0] ST_PR_MUL = 4'd14;
    localparam logic [3:0] ST_PR_OUT = 4'd15;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = RD_SWAP;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.key_wr = s_tvalid;
                if (s_tvalid && s_tlast) begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT: begin
                cmd.init   = 1'b1;
                state_next = ST_NEXT;
            end
            ST_NEXT: begin
                if (!status.k_done) begin
                    state_next = ST_FETCH;
                end else if (!status.round_last) begin
                    cmd.round_next = 1'b1;
                end else if (status.mode) begin
                    state_next = ST_PR_RD;
                end else begin
                    state_next = ST_DN_RD;
                end
            end
            ST_FETCH: begin
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                cmd.load   = 1'b1;
                state_next = ST_CHK;
            end
            ST_CHK: begin
                state_next = status.swap_needed ? ST_SW_RD : ST_ADV;
            end
            ST_SW_RD: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_SWAP;
                state_next = ST_SW_WA;
            end
            ST_SW_WA: begin
                cmd.wr_a   = 1'b1;
                state_next = ST_SW_WB;
            end
            ST_SW_WB: begin
                cmd.wr_b     = 1'b1;
                cmd.swap_inc = 1'b1;
                state_next   = status.swap_last ? ST_ADV : ST_SW_RD;
            end
            ST_ADV: begin
                cmd.adv    = 1'b1;
                state_next = ST_NEXT;
            end
            ST_DN_RD: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_DENSE;
                state_next = ST_DN_AC;
            end
            ST_DN_AC: begin
                cmd.acc_upd   = 1'b1;
                cmd.dense_inc = 1'b1;
                state_next    = status.grp_end ? ST_DN_OUT : ST_DN_RD;
            end
            ST_DN_OUT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    if (status.dense_done) begin
                        cmd.clr_count = 1'b1;
                        state_next    = ST_IDLE;
                    end else begin
                        state_next = ST_DN_RD;
                    end
                end
            end
            ST_PR_RD: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_PROD;
                state_next = ST_PR_MUL;
            end
            ST_PR_MUL: begin
                cmd.prod_load = 1'b1;
                state_next    = ST_PR_OUT;
            end
            ST_PR_OUT: begin
                if (status.out_free) begin
                    cmd.out_load  = 1'b1;
                    cmd.clr_count = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hdl/kh_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module kh_dpath
    import kh_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_we,
    input  wire logic               cfg_wdata,
    input  wire logic [LEN_W-1:0]   in_length,
    input  kh_cmd_t                 cmd,
    output kh_status_t              status,
    input  wire logic               m_tready,
    output logic                    m_tvalid,
    output logic [VALUE_W-1:0]      m_value,
    output logic                    m_last
);

    logic [DATA_W-1:0]  perm_mem [LIST_SIZE];
    logic [LIST_SIZE-1:0] valid_reg;
    logic [LEN_W-1:0]   key_mem [MAX_KEY];

    logic               mode_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [K_W-1:0]     k_reg;
    logic [ROUND_W-1:0] round_reg;
    logic [LIST_AW-1:0] pos_reg;
    logic [LIST_AW-1:0] skip_reg;
    logic [LEN_W-1:0]   len_reg;
    logic [SWAP_W-1:0]  swap_reg;
    logic [LIST_AW-1:0] dense_reg;
    logic [DATA_W-1:0]  acc_reg;
    logic [VALUE_W-1:0] prod_reg;
    logic [LEN_W-1:0]   key_rd_reg;

    logic [DATA_W-1:0]  rd_a_reg;
    logic [DATA_W-1:0]  rd_b_reg;
    logic               hit_a_reg;
    logic               hit_b_reg;
    logic [LIST_AW-1:0] idx_a_reg;
    logic [LIST_AW-1:0] idx_b_reg;

    logic               out_valid_reg;
    logic [VALUE_W-1:0] out_value_reg;
    logic               out_last_reg;

    logic [LIST_AW-1:0] swap_addr_a;
    logic [LIST_AW-1:0] swap_addr_b;
    logic [LIST_AW-1:0] addr_a;
    logic [LIST_AW-1:0] addr_b;
    logic [DATA_W-1:0]  val_a;
    logic [DATA_W-1:0]  val_b;
    logic               wr_en;
    logic [LIST_AW-1:0] wr_addr;
    logic [DATA_W-1:0]  wr_data;
    logic [K_W-1:0]     total;
    logic [K_W-1:0]     suffix_off;
    logic [LEN_W-1:0]   next_len;
    logic [LIST_AW-1:0] half;

    assign swap_addr_a = pos_reg + LIST_AW'(swap_reg);
    assign swap_addr_b = pos_reg + len_reg[LIST_AW-1:0] - LIST_AW'(1) - LIST_AW'(swap_reg);

    always_comb begin
        addr_a = swap_addr_a;
        addr_b = swap_addr_b;
        unique case (cmd.rd_sel)
            RD_SWAP: begin
                addr_a = swap_addr_a;
                addr_b = swap_addr_b;
            end
            RD_DENSE: begin
                addr_a = dense_reg;
                addr_b = dense_reg;
            end
            RD_PROD: begin
                addr_a = LIST_AW'(0);
                addr_b = LIST_AW'(1);
            end
            default: begin
                addr_a = swap_addr_a;
                addr_b = swap_addr_b;
            end
        endcase
    end

    assign val_a = hit_a_reg ? rd_a_reg : idx_a_reg;
    assign val_b = hit_b_reg ? rd_b_reg : idx_b_reg;

    assign wr_en   = cmd.wr_a | cmd.wr_b;
    assign wr_addr = cmd.wr_a ? swap_addr_a : swap_addr_b;
    assign wr_data = cmd.wr_a ? val_b : val_a;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            perm_mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en) begin
            rd_a_reg  <= perm_mem[addr_a];
            rd_b_reg  <= perm_mem[addr_b];
            hit_a_reg <= valid_reg[addr_a];
            hit_b_reg <= valid_reg[addr_b];
            idx_a_reg <= addr_a;
            idx_b_reg <= addr_b;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.init) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.key_wr && (count_reg < COUNT_W'(MAX_KEY))) begin
            key_mem[count_reg[KEY_AW-1:0]] <= in_length;
        end
        key_rd_reg <= key_mem[k_reg[KEY_AW-1:0]];
    end

    assign total      = mode_reg ? K_W'(count_reg) : K_W'(count_reg) + K_W'(SUFFIX_LEN);
    assign suffix_off = k_reg - K_W'(count_reg);
    assign next_len   = (k_reg < K_W'(count_reg)) ? key_rd_reg
                                                 : suffix_len(suffix_off[SUFFIX_AW-1:0]);
    assign half       = len_reg[LIST_AW:1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= 1'b0;
            count_reg <= '0;
            k_reg     <= '0;
            round_reg <= '0;
            pos_reg   <= '0;
            skip_reg  <= '0;
            swap_reg  <= '0;
            dense_reg <= '0;
            acc_reg   <= '0;
        end else begin
            if (cfg_we) begin
                mode_reg <= cfg_wdata;
            end
            if (cmd.clr_count) begin
                count_reg <= '0;
            end else if (cmd.key_wr && (count_reg < COUNT_W'(MAX_KEY))) begin
                count_reg <= count_reg + COUNT_W'(1);
            end
            if (cmd.init) begin
                k_reg     <= '0;
                round_reg <= '0;
                pos_reg   <= '0;
                skip_reg  <= '0;
                dense_reg <= '0;
                acc_reg   <= '0;
            end else begin
                if (cmd.round_next) begin
                    k_reg     <= '0;
                    round_reg <= round_reg + ROUND_W'(1);
                end else if (cmd.adv) begin
                    k_reg <= k_reg + K_W'(1);
                end
                if (cmd.adv) begin
                    pos_reg  <= pos_reg + len_reg[LIST_AW-1:0] + skip_reg;
                    skip_reg <= skip_reg + LIST_AW'(1);
                end
                if (cmd.dense_inc) begin
                    dense_reg <= dense_reg + LIST_AW'(1);
                end
                if (cmd.out_load) begin
                    acc_reg <= '0;
                end else if (cmd.acc_upd) begin
                    acc_reg <= acc_reg ^ val_a;
                end
            end
            if (cmd.load) begin
                swap_reg <= '0;
            end else if (cmd.swap_inc) begin
                swap_reg <= swap_reg + SWAP_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            len_reg <= next_len;
        end
        if (cmd.prod_load) begin
            prod_reg <= VALUE_W'(val_a) * VALUE_W'(val_b);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_value_reg <= mode_reg ? prod_reg : VALUE_W'(acc_reg);
            out_last_reg  <= mode_reg | (dense_reg == '0);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_value  = out_value_reg;
    assign m_last   = out_last_reg;

    assign status.mode        = mode_reg;
    assign status.k_done      = (k_reg == total);
    assign status.round_last  = mode_reg | (round_reg == ROUND_W'(ROUNDS - 1));
    assign status.swap_needed = (len_reg <= LEN_W'(LIST_SIZE)) && (half != '0);
    assign status.swap_last   = (LIST_AW'(swap_reg) == half - LIST_AW'(1));
    assign status.grp_end     = (dense_reg[GRP_AW-1:0] == '1);
    assign status.dense_done  = (dense_reg == '0);
    assign status.out_free    = !out_valid_reg || m_tready;

endmodule

`default_nettype wire

FILE: hdl/knot_hash_engine_core.sv
// Key items are taken one per cycle while idle; the item marked last starts
// the hash. Each length is loaded and checked, then swapped pair by pair (one
// list memory read, two writes per swap); a full hash XORs each group of 16
// list entries into a dense byte, the single-round product multiplies the first
// two. Input stays blocked until the final result is in the output register.
// Reset is synchronous and active low; it clears mode, key count and list state.
`timescale 1ns / 1ps
`default_nettype none

module knot_hash_engine_core
    import kh_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic        cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // length[8:0], zero fill
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // value[15:0]
    output logic             m_tlast
);

    kh_cmd_t    cmd;
    kh_status_t status;

    kh_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    kh_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_length (s_tdata[LEN_W-1:0]),
        .cmd       (cmd),
        .status    (status),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_value   (m_tdata),
        .m_last    (m_tlast)
    );

endmodule

`default_nettype wire

FILE: hdl/kh_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module kh_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        s_tlast,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic        m_tlast
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("Output item changed while stalled.");

    a_busy_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("Input accepted right after the last key item.");

    a_dense_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> (m_tdata[15:8] == 8'd0))
        else $error("Non-final result is wider than a byte.");

    a_result_from_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("Result appeared while the input side was open.");

endmodule

bind knot_hash_engine_core kh_checker u_kh_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
